// ----- rtl/ylp_pkg.sv -----
package ylp_pkg;

  localparam int MAX_DIM  = 4096;
  localparam int DIM_W    = $clog2(MAX_DIM) + 1;  // holds MAX_DIM itself
  localparam int CNT_W    = $clog2(MAX_DIM);      // row / column position
  localparam int SAMPLE_W = 8;
  localparam int PLANE_W  = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  localparam logic [SAMPLE_W-1:0] PAD_LUMA   = 8'd0;
  localparam logic [SAMPLE_W-1:0] PAD_CHROMA = 8'd128;

  localparam logic [DIM_W-1:0] RST_OUT_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RST_OUT_HEIGHT = 13'd1080;
  localparam logic [DIM_W-1:0] RST_FIT_WIDTH  = 13'd1440;
  localparam logic [DIM_W-1:0] RST_FIT_HEIGHT = 13'd1080;

  typedef enum logic [1:0] {
    REG_OUT_WIDTH  = 2'd0,
    REG_OUT_HEIGHT = 2'd1,
    REG_FIT_WIDTH  = 2'd2,
    REG_FIT_HEIGHT = 2'd3
  } reg_idx_t;

  // Picture window and plane extents, derived from the size registers
  typedef struct packed {
    logic             pillar;
    logic [DIM_W-1:0] l_start;
    logic [DIM_W-1:0] l_end;
    logic [DIM_W-1:0] c_start;
    logic [DIM_W-1:0] c_end;
    logic [CNT_W-1:0] lw_m1;
    logic [CNT_W-1:0] cw_m1;
    logic [CNT_W-1:0] lh_m1;
    logic [CNT_W-1:0] ch_m1;
  } win_t;

  // One classified word waiting for the back end
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                in_win;
    logic [PLANE_W-1:0]  plane;
    logic                frame_end;
  } entry_t;

endpackage

// ----- rtl/ylp_if.sv -----
interface ylp_in_if;
  import ylp_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] offered_sample;

  modport source (output valid, output offered_sample, input ready);
  modport sink   (input valid, input offered_sample, output ready);
endinterface

interface ylp_out_if;
  import ylp_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] pixel_value;
  logic [PLANE_W-1:0]  plane_id;
  logic                sample_taken;
  logic                frame_end;

  modport source (output valid, output pixel_value, output plane_id,
                  output sample_taken, output frame_end, input ready);
  modport sink   (input valid, input pixel_value, input plane_id,
                  input sample_taken, input frame_end, output ready);
endinterface

// ----- rtl/ylp_cfg.sv -----
module ylp_cfg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ylp_pkg::ADDR_W-1:0] paddr,
  input  logic [ylp_pkg::DATA_W-1:0] pwdata,
  output logic [ylp_pkg::DATA_W-1:0] prdata,
  output ylp_pkg::win_t          win,
  output logic                   busy
);
  import ylp_pkg::*;

  logic [DIM_W-1:0] out_width;
  logic [DIM_W-1:0] out_height;
  logic [DIM_W-1:0] fit_width;
  logic [DIM_W-1:0] fit_height;
  reg_idx_t         idx;
  logic             wr;

  logic [DIM_W-1:0] w, h, fw_s, fh_s, fw, fh, diff, fit_sel, l_start, l_end;
  win_t             win_next;

  // Force even, clamp to [2, MAX_DIM]
  function automatic logic [DIM_W-1:0] sanitize(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] e;
    e = {v[DIM_W-1:1], 1'b0};
    if (e < DIM_W'(2))
      e = DIM_W'(2);
    else if (e > DIM_W'(MAX_DIM))
      e = DIM_W'(MAX_DIM);
    return e;
  endfunction

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= RST_OUT_WIDTH;
      out_height <= RST_OUT_HEIGHT;
      fit_width  <= RST_FIT_WIDTH;
      fit_height <= RST_FIT_HEIGHT;
    end else if (wr) begin
      unique case (idx)
        REG_OUT_WIDTH:  out_width  <= pwdata[DIM_W-1:0];
        REG_OUT_HEIGHT: out_height <= pwdata[DIM_W-1:0];
        REG_FIT_WIDTH:  fit_width  <= pwdata[DIM_W-1:0];
        REG_FIT_HEIGHT: fit_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OUT_WIDTH:  prdata = DATA_W'(out_width);
      REG_OUT_HEIGHT: prdata = DATA_W'(out_height);
      REG_FIT_WIDTH:  prdata = DATA_W'(fit_width);
      REG_FIT_HEIGHT: prdata = DATA_W'(fit_height);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    w       = sanitize(out_width);
    h       = sanitize(out_height);
    fw_s    = sanitize(fit_width);
    fh_s    = sanitize(fit_height);
    fw      = (fw_s > w) ? w : fw_s;
    fh      = (fh_s > h) ? h : fh_s;
    win_next.pillar = (fh == h);
    diff    = win_next.pillar ? (w - fw) : (h - fh);
    fit_sel = win_next.pillar ? fw : fh;
    l_start = diff >> 1;
    l_end   = l_start + fit_sel;
    win_next.l_start = l_start;
    win_next.l_end   = l_end;
    win_next.c_start = l_start >> 1;
    win_next.c_end   = l_end >> 1;
    win_next.lw_m1   = CNT_W'(w - DIM_W'(1));
    win_next.cw_m1   = CNT_W'((w >> 1) - DIM_W'(1));
    win_next.lh_m1   = CNT_W'(h - DIM_W'(1));
    win_next.ch_m1   = CNT_W'((h >> 1) - DIM_W'(1));
  end

  // Window registers follow the size registers in the next cycle; hold busy meanwhile
  always_ff @(posedge clk) begin
    win <= win_next;
    if (rst)
      busy <= 1'b1;
    else
      busy <= wr;
  end

endmodule

// ----- rtl/ylp_front.sv -----
module ylp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  ylp_pkg::win_t            win,
  input  logic                     cfg_busy,
  input  logic                     q_full,
  input  logic                     in_valid,
  input  logic [ylp_pkg::SAMPLE_W-1:0] in_sample,
  output logic                     in_ready,
  output logic                     push,
  output ylp_pkg::entry_t          push_entry
);
  import ylp_pkg::*;

  logic [PLANE_W-1:0] plane_counter;
  logic [CNT_W-1:0]   row_counter;
  logic [CNT_W-1:0]   column_counter;

  logic [PLANE_W-1:0] plane;
  logic               chroma;
  logic [CNT_W-1:0]   pw_m1, ph_m1, col, row, coord;
  logic [DIM_W-1:0]   start, stop;
  logic               in_win, last_col, last_row;

  assign in_ready = !q_full && !cfg_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    plane    = (plane_counter > PLANE_V) ? PLANE_Y : plane_counter;
    chroma   = (plane != PLANE_Y);
    pw_m1    = chroma ? win.cw_m1 : win.lw_m1;
    ph_m1    = chroma ? win.ch_m1 : win.lh_m1;
    // pull back a position left outside a plane that shrank
    col      = (column_counter > pw_m1) ? pw_m1 : column_counter;
    row      = (row_counter > ph_m1) ? ph_m1 : row_counter;
    coord    = win.pillar ? col : row;
    start    = chroma ? win.c_start : win.l_start;
    stop     = chroma ? win.c_end : win.l_end;
    in_win   = ({1'b0, coord} >= start) && ({1'b0, coord} < stop);
    last_col = (col == pw_m1);
    last_row = (row == ph_m1);
    push_entry.sample    = in_sample;
    push_entry.in_win    = in_win;
    push_entry.plane     = plane;
    push_entry.frame_end = (plane == PLANE_V) && last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_counter  <= PLANE_Y;
      row_counter    <= '0;
      column_counter <= '0;
    end else if (push) begin
      if (!last_col) begin
        column_counter <= col + CNT_W'(1);
        row_counter    <= row;
        plane_counter  <= plane;
      end else begin
        column_counter <= '0;
        if (!last_row) begin
          row_counter   <= row + CNT_W'(1);
          plane_counter <= plane;
        end else begin
          row_counter   <= '0;
          plane_counter <= (plane == PLANE_V) ? PLANE_Y : plane + PLANE_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/ylp_queue.sv -----
module ylp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ylp_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ylp_pkg::entry_t head
);
  import ylp_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)
        wr_ptr <= !wr_ptr;
      if (pop)
        rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/ylp_back.sv -----
module ylp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  ylp_pkg::entry_t head,
  output logic            pop,
  ylp_out_if.source       pixels
);
  import ylp_pkg::*;

  logic out_valid;

  assign pop          = !q_empty && (!out_valid || pixels.ready);
  assign pixels.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (!out_valid || pixels.ready)
      out_valid <= !q_empty;
    if (pop) begin
      pixels.pixel_value  <= head.in_win ? head.sample :
                             ((head.plane == PLANE_Y) ? PAD_LUMA : PAD_CHROMA);
      pixels.plane_id     <= head.plane;
      pixels.sample_taken <= head.in_win;
      pixels.frame_end    <= head.frame_end;
    end
  end

endmodule

// ----- rtl/yuv420_letterbox_padder.sv -----
// YUV 4:2:0 letterbox / pillarbox padder. Every word taken on samples yields
// exactly one word on pixels, walking the output frame in raster order over
// Y, then U, then V; sample_taken tells upstream whether the offered sample
// was used or must be offered again. Sustained rate is one word per clock
// while pixels.ready is high: the front end classifies a word in the cycle
// it is accepted, a two-entry queue carries it to the back end, and the
// output register shows it once popped. samples.ready drops only while
// the queue is full and for one cycle after each register write, while the
// window boundaries are recomputed from the size registers (also for one
// cycle after reset). Registers: out_width at 0x0, out_height at 0x4, fit_width
// at 0x8, fit_height at 0xC, 13 bits each; write them only while the block is idle.
module yuv420_letterbox_padder (
  input  logic                       clk,
  input  logic                       rst,
  ylp_in_if.sink                     samples,
  ylp_out_if.source                  pixels,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ylp_pkg::ADDR_W-1:0] paddr,
  input  logic [ylp_pkg::DATA_W-1:0] pwdata,
  output logic [ylp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ylp_pkg::*;

  win_t   win;
  logic   cfg_busy;
  logic   q_full, q_empty, push, pop, in_ready;
  entry_t push_entry, head;

  assign pready        = 1'b1;
  assign samples.ready = in_ready;

  ylp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .win     (win),
    .busy    (cfg_busy)
  );

  ylp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .win        (win),
    .cfg_busy   (cfg_busy),
    .q_full     (q_full),
    .in_valid   (samples.valid),
    .in_sample  (samples.offered_sample),
    .in_ready   (in_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  ylp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  ylp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .pixels  (pixels)
  );

endmodule

// ----- rtl/ylp_checker.sv -----
module ylp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        pix_valid,
  input logic                        pix_ready,
  input logic [ylp_pkg::SAMPLE_W-1:0] pixel_value,
  input logic [ylp_pkg::PLANE_W-1:0]  plane_id,
  input logic                        sample_taken,
  input logic                        frame_end
);
  import ylp_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid)
    else $error("pixel word dropped while stalled");

  a_plane_code: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> plane_id <= PLANE_V)
    else $error("unused plane code on output");

  a_frame_end_v: assert property (@(posedge clk) disable iff (rst)
    pix_valid && frame_end |-> plane_id == PLANE_V)
    else $error("frame end outside V plane");

  a_pad_value: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !sample_taken |->
      ((plane_id == PLANE_Y) ? (pixel_value == PAD_LUMA) : (pixel_value == PAD_CHROMA)))
    else $error("wrong padding value");

endmodule

bind yuv420_letterbox_padder ylp_checker u_ylp_checker (
  .clk          (clk),
  .rst          (rst),
  .pix_valid    (pixels.valid),
  .pix_ready    (pixels.ready),
  .pixel_value  (pixels.pixel_value),
  .plane_id     (pixels.plane_id),
  .sample_taken (pixels.sample_taken),
  .frame_end    (pixels.frame_end)
);
